// ===== design/sorted_disjoint_span_table_macros.svh =====
// ----------------------------------------------------------------------------
// Span table assertion macros
// Shared concurrent assertion forms for the span table checkers.
// ----------------------------------------------------------------------------
`ifndef SORTED_DISJOINT_SPAN_TABLE_MACROS_SVH
`define SORTED_DISJOINT_SPAN_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define STDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span table check failed");

// Next-cycle implication, disabled while in reset
`define STDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span table check failed");

`endif

// ===== design/stdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Span table package
// Field widths, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
package stdt_pkg;

    localparam int SPAN_W       = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;
    localparam int READ_INDEX_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_READ_BAD = 3'd5
    } status_t;

    typedef struct packed {
        logic [SPAN_W-1:0] start_pos;
        logic [SPAN_W-1:0] end_pos;
    } span_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic  commit;
        span_t span;
    } cell_ctl_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
        span_t              entry;
    } result_t;

endpackage

// ===== design/sorted_disjoint_span_table.sv =====
// ----------------------------------------------------------------------------
// Sorted disjoint span table
// Row of span cells kept sorted by start, with insert, clear and read.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Beat
// in       sink       in_valid / in_stall   operation, span_start, span_end, read_index
// out      source     out_valid / out_stall status, entry_count, entry_start, entry_end
//
// One beat per cycle while in_stall is low: every cell compares its start and
// shifts in the same cycle; each result is registered into the head or skid slot.
// A two-deep result buffer (head plus skid) lets input run on while a result
// waits; in_stall rises only when both slots are taken.
// Reset clears the count and the buffer valid flags; span storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_disjoint_span_table
    import stdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         operation,
    input  logic [SPAN_W-1:0]       span_start,
    input  logic [SPAN_W-1:0]       span_end,
    input  logic [READ_INDEX_W-1:0] read_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [COUNT_W-1:0]      entry_count,
    output logic [SPAN_W-1:0]       entry_start,
    output logic [SPAN_W-1:0]       entry_end
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IX_W  = CNT_W + READ_INDEX_W;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    logic [IX_W-1:0]          idx_ext;
    logic [IX_W-1:0]          cnt_ix;

    logic [TABLE_DEPTH-1:0] held;
    logic [TABLE_DEPTH-1:0] after;
    logic [TABLE_DEPTH-1:0] drop;
    logic [TABLE_DEPTH-1:0] rd_hit;
    span_t                  span_q  [TABLE_DEPTH];
    span_t                  rd_span [TABLE_DEPTH];

    cell_ctl_t ctl;
    logic      accept;
    logic      commit;
    logic      full;
    logic      drop_any;
    logic      rd_in_range;
    span_t     rd_any;
    result_t   res;

    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    pop;

    assign accept = in_valid && !in_stall;
    assign pop    = out_valid_reg && !out_stall;

    assign idx_ext     = {{CNT_W{1'b0}}, read_index};
    assign cnt_ix      = {{READ_INDEX_W{1'b0}}, count_reg};
    assign full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign drop_any    = |drop;
    assign rd_in_range = (idx_ext < cnt_ix);

    assign ctl.commit          = commit;
    assign ctl.span.start_pos  = span_start;
    assign ctl.span.end_pos    = span_end;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic  left_held;
        logic  left_after;
        span_t left_span;

        assign held[g]   = (count_reg > CNT_W'(g));
        assign rd_hit[g] = (idx_ext == IX_W'(g));

        if (g == 0)
        begin : g_first
            assign left_held  = 1'b0;
            assign left_after = 1'b0;
            assign left_span  = '0;
        end
        else
        begin : g_rest
            assign left_held  = held[g-1];
            assign left_after = after[g-1];
            assign left_span  = span_q[g-1];
        end

        stdt_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .held       (held[g]),
            .rd_hit     (rd_hit[g]),
            .left_held  (left_held),
            .left_after (left_after),
            .left_span  (left_span),
            .after      (after[g]),
            .span       (span_q[g]),
            .drop       (drop[g]),
            .rd_span    (rd_span[g])
        );
    end

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rd_any = rd_any | rd_span[i];
        end
    end

    // ------------------------------------------------------------------
    // Operation decode and result
    // ------------------------------------------------------------------
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        count_next = count_reg;
        commit     = 1'b0;
        res.status = ST_READ_BAD;
        res.entry  = '0;
        unique case (op_t'(operation))
            OP_INSERT:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else if (drop_any)
                begin
                    res.status = ST_DROPPED;
                end
                else
                begin
                    commit     = accept;
                    count_next = count_reg + CNT_W'(1);
                    res.status = ST_INSERTED;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                res.status = ST_CLEARED;
            end
            OP_READ:
            begin
                if (rd_in_range)
                begin
                    res.status = ST_READ_OK;
                    res.entry  = rd_any;
                end
            end
            default:
            begin
                res.status = ST_READ_BAD;
            end
        endcase
        res.entry_count = count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: head slot drives the port, skid slot catches a beat
    // that arrives while the head is stalled
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
                if (accept)
                begin
                    skid_next       = res;
                    skid_valid_next = 1'b1;
                end
            end
            else if (accept)
            begin
                head_next = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg)
            begin
                head_next      = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign status      = head_reg.status;
    assign entry_count = head_reg.entry_count;
    assign entry_start = head_reg.entry.start_pos;
    assign entry_end   = head_reg.entry.end_pos;

endmodule

// ===== design/stdt_cell.sv =====
// ----------------------------------------------------------------------------
// Span table cell
// Holds one span; compares against the incoming start and shifts up on insert.
// ----------------------------------------------------------------------------
module stdt_cell
    import stdt_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      held,
    input  logic      rd_hit,
    input  logic      left_held,
    input  logic      left_after,
    input  span_t     left_span,
    output logic      after,
    output span_t     span,
    output logic      drop,
    output span_t     rd_span
);

    span_t span_reg;
    span_t span_next;
    logic  is_place;

    // Table is sorted, so 'after' is monotonic along the row
    assign after    = !held || (span_reg.start_pos > ctl.span.start_pos);
    assign is_place = after && !left_after;

    assign drop = is_place
        && ((left_held && (left_span.end_pos > ctl.span.start_pos))
            || (held && (ctl.span.end_pos > span_reg.start_pos)));

    always_comb
    begin
        span_next = span_reg;
        if (ctl.commit && after)
        begin
            span_next = left_after ? left_span : ctl.span;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    assign span    = span_reg;
    assign rd_span = rd_hit ? span_reg : '0;

endmodule

// ===== design/stdt_checker.sv =====
// ----------------------------------------------------------------------------
// Span table port checker
// Watches the top level's ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "sorted_disjoint_span_table_macros.svh"

module stdt_checker
    import stdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [STATUS_W-1:0]     status,
    input logic [COUNT_W-1:0]      entry_count,
    input logic [SPAN_W-1:0]       entry_start,
    input logic [SPAN_W-1:0]       entry_end
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

    logic [STATUS_W+COUNT_W+2*SPAN_W-1:0] out_beat;
    logic [2*SPAN_W-1:0]                  out_entry;

    assign out_beat  = {status, entry_count, entry_start, entry_end};
    assign out_entry = {entry_start, entry_end};

    // A stalled result beat holds
    `STDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

    // Only a good read carries span data
    `STDT_ASSERT_IMPLY(a_entry_zero, clk, rst_n, out_valid && (status != ST_READ_OK), out_entry == '0)

    // A clear always leaves the table empty
    `STDT_ASSERT_IMPLY(a_clear_empty, clk, rst_n, out_valid && (status == ST_CLEARED), entry_count == '0)

    // Full is reported only with the table at capacity
    `STDT_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), entry_count == FULL_COUNT)

endmodule

bind sorted_disjoint_span_table stdt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_stdt_checker (.*);
